FILE: rtl/core/mfps_pkg.sv
// Package: shared constants, types and register indexes of the motor fader servo.
`default_nettype none

package mfps_pkg;

    localparam int SAMPLE_W      = 12;
    localparam int WINDOW_DEF    = 10;
    localparam int CFG_IDX_W     = 3;
    localparam int ON_TIME_W     = 4;
    localparam int PULSE_W       = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_TIER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MID_TIER     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_TIER     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_DELTA = 3'd4;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] DEADBAND_RST     = 12'd200;
    localparam logic [SAMPLE_W-1:0] NEAR_TIER_RST    = 12'd1000;
    localparam logic [SAMPLE_W-1:0] MID_TIER_RST     = 12'd2000;
    localparam logic [SAMPLE_W-1:0] FAR_TIER_RST     = 12'd3000;
    localparam logic [SAMPLE_W-1:0] REPORT_DELTA_RST = 12'd200;

    // Pulse lengths in milliseconds
    localparam logic [ON_TIME_W-1:0] MS_FAR       = 4'd10;
    localparam logic [ON_TIME_W-1:0] MS_MID_DOWN  = 4'd10;
    localparam logic [ON_TIME_W-1:0] MS_MID_UP    = 4'd8;
    localparam logic [ON_TIME_W-1:0] MS_NEAR      = 4'd4;
    localparam logic [ON_TIME_W-1:0] MS_FINE      = 4'd2;

    typedef enum logic [1:0] {
        DIR_OFF  = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef enum logic {
        KIND_REPORT = 1'b0,
        KIND_SEEK   = 1'b1
    } kind_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] deadband;
        logic [SAMPLE_W-1:0] near_tier;
        logic [SAMPLE_W-1:0] mid_tier;
        logic [SAMPLE_W-1:0] far_tier;
        logic [SAMPLE_W-1:0] report_delta;
    } cfg_t;

    typedef struct packed {
        dir_t                 dir;
        logic [ON_TIME_W-1:0] on_time;
        logic [PULSE_W-1:0]   pulses;
        logic                 arrived;
    } seek_t;

endpackage

`default_nettype wire

FILE: rtl/core/motor_fader_position_servo_top.sv
// Top level: motor fader position servo with moving-average ring and report logic.
// Path: an accepted input beat passes the input register, then the result register.
// Throughput: one beat per cycle unless stalled; the ring update, divide by WINDOW
//   and seek decision all sit in one stage between the input and result registers.
// Reset: asynchronous, active low; clears the ring, pointer, sum, last report,
//   both pipeline valids and loads the configuration reset values.
`default_nettype none

module motor_fader_position_servo_top
    import mfps_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // configuration write port
    input  wire logic                 cfg_wen,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SAMPLE_W-1:0]  cfg_wdata,

    // input channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 kind,
    input  wire logic [SAMPLE_W-1:0]  sample,
    input  wire logic [SAMPLE_W-1:0]  target,

    // result channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [SAMPLE_W-1:0]       average,
    output logic [1:0]                drive_dir,
    output logic [ON_TIME_W-1:0]      on_time_ms,
    output logic [PULSE_W-1:0]        pulse_count,
    output logic                      arrived,
    output logic                      report_valid
);

    // Sum must hold WINDOW full-scale samples
    localparam int SUM_W = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

    // Divide by WINDOW as a multiply by a rounded-up reciprocal and a shift;
    // exact for every sum that fits in SUM_W bits.
    localparam int DIV_SH = SUM_W + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
    localparam longint DIV_MUL_L =
        ((longint'(1) << DIV_SH) + longint'(WINDOW) - 1) / longint'(WINDOW);
    localparam logic [SUM_W:0] DIV_MUL = (SUM_W+1)'(DIV_MUL_L);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband     <= DEADBAND_RST;
            cfg_reg.near_tier    <= NEAR_TIER_RST;
            cfg_reg.mid_tier     <= MID_TIER_RST;
            cfg_reg.far_tier     <= FAR_TIER_RST;
            cfg_reg.report_delta <= REPORT_DELTA_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_DEADBAND:     cfg_reg.deadband     <= cfg_wdata;
                REG_NEAR_TIER:    cfg_reg.near_tier    <= cfg_wdata;
                REG_MID_TIER:     cfg_reg.mid_tier     <= cfg_wdata;
                REG_FAR_TIER:     cfg_reg.far_tier     <= cfg_wdata;
                REG_REPORT_DELTA: cfg_reg.report_delta <= cfg_wdata;
                default:          ; // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register stage
    // ------------------------------------------------------------------
    logic                in_vld_reg;
    logic                kind_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] target_reg;

    logic out_load;   // result register can take a new beat this cycle
    logic advance;    // input stage hands its beat to the result stage

    assign out_load = !out_valid || !out_stall;
    assign advance  = in_vld_reg && out_load;
    // Accept whenever the input stage is empty or draining this cycle, so a
    // new beat arrives while a finished result still waits downstream.
    assign in_stall = in_vld_reg && !out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!in_stall)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            kind_reg   <= kind;
            sample_reg <= sample;
            target_reg <= target;
        end
    end

    // ------------------------------------------------------------------
    // Ring of recent samples, running sum and average
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] ring_reg [WINDOW];
    logic [PTR_W-1:0]    ptr_reg;
    logic [PTR_W-1:0]    ptr_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [2*SUM_W:0]    avg_prod;
    logic [SAMPLE_W-1:0] avg;

    // Swap the oldest sample for the new one; the sum never goes below zero
    // because it already contains the sample leaving the window.
    assign sum_next = sum_reg - SUM_W'(ring_reg[ptr_reg]) + SUM_W'(sample_reg);
    assign avg_prod = (2*SUM_W+1)'(sum_next) * (2*SUM_W+1)'(DIV_MUL);
    assign avg      = avg_prod[DIV_SH +: SAMPLE_W];
    assign ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + PTR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
                ring_reg[i] <= '0;
            ptr_reg <= '0;
            sum_reg <= '0;
        end
        else if (advance)
        begin
            ring_reg[ptr_reg] <= sample_reg;
            ptr_reg           <= ptr_next;
            sum_reg           <= sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Seek decision and report check
    // ------------------------------------------------------------------
    seek_t seek;

    mfps_seek u_seek (
        .average (avg),
        .target  (target_reg),
        .cfg     (cfg_reg),
        .seek    (seek)
    );

    logic [SAMPLE_W-1:0] last_rep_reg;
    logic [SAMPLE_W-1:0] rep_diff;
    logic                rep_check;  // this beat runs the report check
    logic                rep_fire;
    logic                is_seek;

    assign is_seek   = (kind_t'(kind_reg) == KIND_SEEK);
    // Report-only beats always check; seek beats check only on arrival
    assign rep_check = !is_seek || seek.arrived;
    assign rep_diff  = (avg > last_rep_reg) ? (avg - last_rep_reg) : (last_rep_reg - avg);
    assign rep_fire  = rep_check && (rep_diff > cfg_reg.report_delta);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_rep_reg <= '0;
        else if (advance && rep_fire)
            last_rep_reg <= avg;
    end

    // ------------------------------------------------------------------
    // Result register stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (out_load)
            out_valid <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            average      <= avg;
            report_valid <= rep_fire;
            if (is_seek)
            begin
                drive_dir   <= seek.dir;
                on_time_ms  <= seek.on_time;
                pulse_count <= seek.pulses;
                arrived     <= seek.arrived;
            end
            else
            begin
                // report-only beat: motor stays off
                drive_dir   <= DIR_OFF;
                on_time_ms  <= '0;
                pulse_count <= '0;
                arrived     <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/mfps_seek.sv
// Seek decision: direction, on-time, pulse count and arrival from average and target.
`default_nettype none

module mfps_seek
    import mfps_pkg::*;
(
    input  wire logic [SAMPLE_W-1:0] average,
    input  wire logic [SAMPLE_W-1:0] target,
    input  wire cfg_t                cfg,
    output seek_t                    seek
);

    logic                 down;
    logic [SAMPLE_W-1:0]  distance;
    logic                 fine;
    logic                 joined;
    logic [ON_TIME_W-1:0] tier_ms;

    always_comb
    begin
        down     = average > target;
        distance = down ? (average - target) : (target - average);
        fine     = distance > cfg.deadband;

        // Pick the first tier the distance exceeds, far before mid before near
        joined  = 1'b0;
        tier_ms = '0;
        if (distance > cfg.far_tier)
        begin
            tier_ms = MS_FAR;
            joined  = 1'b1;
        end
        else if (distance > cfg.mid_tier)
        begin
            tier_ms = down ? MS_MID_DOWN : MS_MID_UP;
            joined  = 1'b1;
        end
        else if (distance > cfg.near_tier)
        begin
            tier_ms = MS_NEAR;
        end

        seek.dir     = DIR_OFF;
        seek.on_time = '0;
        seek.pulses  = '0;
        if ((distance != '0) && ((tier_ms != '0) || fine))
        begin
            seek.dir     = down ? DIR_DOWN : DIR_UP;
            seek.on_time = tier_ms + (fine ? MS_FINE : ON_TIME_W'(0));
            // near tier and fine pulse stay apart; long tiers run into it
            if ((tier_ms != '0) && !joined && fine)
                seek.pulses = PULSE_W'(2);
            else
                seek.pulses = PULSE_W'(1);
        end

        seek.arrived = distance < cfg.deadband;
    end

endmodule

`default_nettype wire
